// ===== rtl/core/table_time_flux_interpolator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the time/flux interpolator
// Clocked on clock, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TABLE_TIME_FLUX_INTERPOLATOR_UNIT_ASSERT_SVH
`define TABLE_TIME_FLUX_INTERPOLATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define TFI_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TFI_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/tfi_pkg.sv =====
// ----------------------------------------------------------------------------
// tfi_pkg
// Widths, step counts and shared types of the time/flux interpolator.
// ----------------------------------------------------------------------------
package tfi_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int INDEX_W     = 8;
   localparam int COUNT_W     = 9;
   localparam int TIME_W      = 38;
   localparam int FLUX_W      = 32;
   localparam int DAY_W       = 22;
   localparam int FRAC_W      = 16;

   localparam int MAG_W       = FLUX_W + 1;
   localparam int PROD_W      = MAG_W + TIME_W;
   localparam int ALU_W       = PROD_W + 1;
   localparam int MUL_STEPS   = TIME_W;
   localparam int DIV_STEPS   = PROD_W;
   localparam int STEP_W      = $clog2(DIV_STEPS);

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;
   localparam logic KIND_VIS  = 1'b0;
   localparam logic KIND_IR   = 1'b1;
   localparam logic STAT_OK   = 1'b0;
   localparam logic STAT_BEYOND = 1'b1;

   typedef struct packed {
      logic [ALU_W-1:0] a;
      logic [ALU_W-1:0] b;
      logic             sub;
   } alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] sum;
      logic             carry;
   } alu_rsp_type;

   typedef struct packed {
      logic [TIME_W-1:0]        stamp;
      logic signed [FLUX_W-1:0] vis;
      logic signed [FLUX_W-1:0] ir;
   } entry_type;

endpackage

// ===== rtl/core/tfi_channels.sv =====
// ----------------------------------------------------------------------------
// Channel interfaces
// Request, response and register-write channels with valid/ready.
// ----------------------------------------------------------------------------
interface tfi_req_if
   import tfi_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic [INDEX_W-1:0]       entry_index;
   logic [TIME_W-1:0]        entry_time;
   logic signed [FLUX_W-1:0] entry_vis;
   logic signed [FLUX_W-1:0] entry_ir;
   logic [DAY_W-1:0]         query_day;
   logic [FRAC_W-1:0]        query_frac;
   logic                     flux_kind;

   modport source (output valid, req_type, entry_index, entry_time, entry_vis, entry_ir,
                   query_day, query_frac, flux_kind, input ready);
   modport sink   (input valid, req_type, entry_index, entry_time, entry_vis, entry_ir,
                   query_day, query_frac, flux_kind, output ready);
endinterface

interface tfi_rsp_if
   import tfi_pkg::*;
();
   logic                     valid;
   logic                     ready;
   logic signed [FLUX_W-1:0] flux_value;
   logic                     status;

   modport source (output valid, flux_value, status, input ready);
   modport sink   (input valid, flux_value, status, output ready);
endinterface

interface tfi_csr_if
   import tfi_pkg::*;
();
   logic               valid;
   logic               ready;
   logic [COUNT_W-1:0] entry_count;

   modport source (output valid, entry_count, input ready);
   modport sink   (input valid, entry_count, output ready);
endinterface

// ===== rtl/core/tfi_addsub.sv =====
// ----------------------------------------------------------------------------
// tfi_addsub
// Shared adder/subtractor; carry out high means no borrow on subtract.
// ----------------------------------------------------------------------------
module tfi_addsub
   import tfi_pkg::*;
(
   input  alu_req_type op,
   output alu_rsp_type res
);

   logic [ALU_W:0] full;

   assign full = {1'b0, op.a} + {1'b0, (op.sub ? ~op.b : op.b)} + {{ALU_W{1'b0}}, op.sub};
   assign res.sum   = full[ALU_W-1:0];
   assign res.carry = full[ALU_W];

endmodule

// ===== rtl/core/table_time_flux_interpolator_unit.sv =====
// ----------------------------------------------------------------------------
// table_time_flux_interpolator_unit
// Piecewise linear interpolation over a table of time/flux entries.
// ----------------------------------------------------------------------------
// A load item writes one table entry and gives no result. A query scans the
// table one entry per cycle through the single read port of the entry
// memory. A hit on entry 0 returns that entry's value, and a hit on an entry
// whose time is not above the one before returns the earlier value. Any other
// hit is interpolated with one shared 72-bit adder: four setup steps, a
// 38-step shift-add multiply and a 71-step restoring divide. A query past the
// table scans every entry in use (entry_count, capped at 256) and reports
// status beyond with flux 0, as does a query on an empty table. A result that
// is not taken stalls the next query in its put state until that result is
// taken; loads are still accepted. The request channel is not ready while a
// query is in progress. entry_count may be written at any time the block is
// idle.
// ----------------------------------------------------------------------------
module table_time_flux_interpolator_unit
   import tfi_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   tfi_req_if.sink   req_ch,
   tfi_rsp_if.source rsp_ch,
   tfi_csr_if.sink   csr_ch
);

`include "table_time_flux_interpolator_unit_assert.svh"

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SEARCH = 4'd1;
   localparam logic [3:0] S_DEN    = 4'd2;
   localparam logic [3:0] S_NUM    = 4'd3;
   localparam logic [3:0] S_DV     = 4'd4;
   localparam logic [3:0] S_MAG    = 4'd5;
   localparam logic [3:0] S_MUL    = 4'd6;
   localparam logic [3:0] S_DIV    = 4'd7;
   localparam logic [3:0] S_FIN    = 4'd8;
   localparam logic [3:0] S_PUT    = 4'd9;

   // entry memory
   entry_type mem_ff [TABLE_DEPTH];
   entry_type rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;

   logic [3:0]               state_ff, state_in;
   logic [COUNT_W-1:0]       count_ff;
   logic [TIME_W-1:0]        tq_ff, tq_in;
   logic                     kind_ff, kind_in;
   logic [CNT_W-1:0]         used_ff, used_in;
   logic [CNT_W-1:0]         scan_ff, scan_in;
   logic [TIME_W-1:0]        prev_time_ff, prev_time_in;
   logic [FLUX_W-1:0]        prev_val_ff, prev_val_in;
   logic [TIME_W-1:0]        hit_time_ff, hit_time_in;
   logic [FLUX_W-1:0]        hit_val_ff, hit_val_in;
   logic [TIME_W-1:0]        den_ff, den_in;
   logic [TIME_W-1:0]        num_ff, num_in;
   logic [MAG_W-1:0]         dv_ff, dv_in;
   logic                     neg_ff, neg_in;
   logic [MAG_W-1:0]         mag_ff, mag_in;
   logic [PROD_W-1:0]        acc_ff, acc_in;
   logic [TIME_W-1:0]        rem_ff, rem_in;
   logic [MAG_W-1:0]         quo_ff, quo_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic [FLUX_W-1:0]        res_ff, res_in;
   logic                     stat_ff, stat_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [FLUX_W-1:0]        rsp_flux_ff, rsp_flux_in;
   logic                     rsp_stat_ff, rsp_stat_in;

   alu_req_type alu_op;
   alu_rsp_type alu_res;

   logic              req_acc;
   logic [CNT_W-1:0]  used_val;
   logic [FLUX_W-1:0] rd_val;
   logic [TIME_W:0]   rs;
   logic              out_free;

   tfi_addsub u_alu (
      .op  (alu_op),
      .res (alu_res)
   );

   assign req_ch.ready     = (state_ff == S_IDLE);
   assign csr_ch.ready     = 1'b1;
   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.flux_value = rsp_flux_ff;
   assign rsp_ch.status    = rsp_stat_ff;

   assign req_acc  = req_ch.valid && req_ch.ready;
   assign wr_en    = req_acc && (req_ch.req_type == REQ_LOAD) &&
                     (32'(req_ch.entry_index) < TABLE_DEPTH);
   assign used_val = (32'(count_ff) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(count_ff);
   assign rd_val   = (kind_ff == KIND_IR) ? rd_data_ff.ir : rd_data_ff.vis;
   assign rs       = {rem_ff, acc_ff[PROD_W-1]};
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign rd_addr  = scan_in[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[ADDR_W'(req_ch.entry_index)] <= '{stamp: req_ch.entry_time,
                                                 vis:   req_ch.entry_vis,
                                                 ir:    req_ch.entry_ir};
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_comb begin
      state_in     = state_ff;
      tq_in        = tq_ff;
      kind_in      = kind_ff;
      used_in      = used_ff;
      scan_in      = scan_ff;
      prev_time_in = prev_time_ff;
      prev_val_in  = prev_val_ff;
      hit_time_in  = hit_time_ff;
      hit_val_in   = hit_val_ff;
      den_in       = den_ff;
      num_in       = num_ff;
      dv_in        = dv_ff;
      neg_in       = neg_ff;
      mag_in       = mag_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      res_in       = res_ff;
      stat_in      = stat_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_flux_in  = rsp_flux_ff;
      rsp_stat_in  = rsp_stat_ff;
      alu_op.a     = '0;
      alu_op.b     = '0;
      alu_op.sub   = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_acc && (req_ch.req_type == REQ_QUERY)) begin
               tq_in   = {req_ch.query_day, req_ch.query_frac};
               kind_in = req_ch.flux_kind;
               used_in = used_val;
               scan_in = '0;
               if (used_val == '0) begin
                  res_in   = '0;
                  stat_in  = STAT_BEYOND;
                  state_in = S_PUT;
               end else begin
                  state_in = S_SEARCH;
               end
            end
         end
         S_SEARCH: begin
            // stored time minus query time, no borrow means a hit
            alu_op.a   = ALU_W'(rd_data_ff.stamp);
            alu_op.b   = ALU_W'(tq_ff);
            alu_op.sub = 1'b1;
            if (alu_res.carry) begin
               hit_time_in = rd_data_ff.stamp;
               hit_val_in  = rd_val;
               if (scan_ff == '0) begin
                  res_in   = rd_val;
                  stat_in  = STAT_OK;
                  state_in = S_PUT;
               end else begin
                  state_in = S_DEN;
               end
            end else begin
               prev_time_in = rd_data_ff.stamp;
               prev_val_in  = rd_val;
               scan_in      = scan_ff + 1'b1;
               if (scan_in == used_ff) begin
                  res_in   = '0;
                  stat_in  = STAT_BEYOND;
                  state_in = S_PUT;
               end
            end
         end
         S_DEN: begin
            alu_op.a   = ALU_W'(hit_time_ff);
            alu_op.b   = ALU_W'(prev_time_ff);
            alu_op.sub = 1'b1;
            den_in     = alu_res.sum[TIME_W-1:0];
            if (!alu_res.carry || (alu_res.sum == '0)) begin
               // earlier time not below the later one: earlier value
               res_in   = prev_val_ff;
               stat_in  = STAT_OK;
               state_in = S_PUT;
            end else begin
               state_in = S_NUM;
            end
         end
         S_NUM: begin
            alu_op.a   = ALU_W'(tq_ff);
            alu_op.b   = ALU_W'(prev_time_ff);
            alu_op.sub = 1'b1;
            num_in     = alu_res.sum[TIME_W-1:0];
            state_in   = S_DV;
         end
         S_DV: begin
            alu_op.a   = {{(ALU_W-FLUX_W){hit_val_ff[FLUX_W-1]}}, hit_val_ff};
            alu_op.b   = {{(ALU_W-FLUX_W){prev_val_ff[FLUX_W-1]}}, prev_val_ff};
            alu_op.sub = 1'b1;
            dv_in      = alu_res.sum[MAG_W-1:0];
            neg_in     = alu_res.sum[ALU_W-1];
            state_in   = S_MAG;
         end
         S_MAG: begin
            alu_op.a   = '0;
            alu_op.b   = {{(ALU_W-MAG_W){dv_ff[MAG_W-1]}}, dv_ff};
            alu_op.sub = 1'b1;
            mag_in     = neg_ff ? alu_res.sum[MAG_W-1:0] : dv_ff;
            acc_in     = '0;
            step_in    = '0;
            state_in   = S_MUL;
         end
         S_MUL: begin
            alu_op.a = ALU_W'({acc_ff[PROD_W-2:0], 1'b0});
            alu_op.b = num_ff[TIME_W-1] ? ALU_W'(mag_ff) : '0;
            acc_in   = alu_res.sum[PROD_W-1:0];
            num_in   = {num_ff[TIME_W-2:0], 1'b0};
            step_in  = step_ff + 1'b1;
            if (step_ff == STEP_W'(MUL_STEPS - 1)) begin
               step_in  = '0;
               rem_in   = '0;
               quo_in   = '0;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            alu_op.a   = ALU_W'(rs);
            alu_op.b   = ALU_W'(den_ff);
            alu_op.sub = 1'b1;
            rem_in     = alu_res.carry ? alu_res.sum[TIME_W-1:0] : rs[TIME_W-1:0];
            quo_in     = {quo_ff[MAG_W-2:0], alu_res.carry};
            acc_in     = {acc_ff[PROD_W-2:0], 1'b0};
            step_in    = step_ff + 1'b1;
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            alu_op.a   = {{(ALU_W-FLUX_W){prev_val_ff[FLUX_W-1]}}, prev_val_ff};
            alu_op.b   = ALU_W'(quo_ff);
            alu_op.sub = neg_ff;
            res_in     = alu_res.sum[FLUX_W-1:0];
            stat_in    = STAT_OK;
            state_in   = S_PUT;
         end
         S_PUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_flux_in  = res_ff;
               rsp_stat_in  = stat_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         scan_ff      <= '0;
         step_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_ff      <= scan_in;
         step_ff      <= step_in;
         if (csr_ch.valid && csr_ch.ready) begin
            count_ff <= csr_ch.entry_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      tq_ff        <= tq_in;
      kind_ff      <= kind_in;
      used_ff      <= used_in;
      prev_time_ff <= prev_time_in;
      prev_val_ff  <= prev_val_in;
      hit_time_ff  <= hit_time_in;
      hit_val_ff   <= hit_val_in;
      den_ff       <= den_in;
      num_ff       <= num_in;
      dv_ff        <= dv_in;
      neg_ff       <= neg_in;
      mag_ff       <= mag_in;
      acc_ff       <= acc_in;
      rem_ff       <= rem_in;
      quo_ff       <= quo_in;
      res_ff       <= res_in;
      stat_ff      <= stat_in;
      rsp_flux_ff  <= rsp_flux_in;
      rsp_stat_ff  <= rsp_stat_in;
   end

   `TFI_ASSERT_NEXT(a_query_blocks, req_acc && (req_ch.req_type == REQ_QUERY), !req_ch.ready, "query accepted but request channel still ready")
   `TFI_ASSERT_NOW(a_scan_range, state_ff == S_SEARCH, scan_ff < used_ff, "scan index past entries in use")
   `TFI_ASSERT_NOW(a_rem_below_den, state_ff == S_DIV, rem_ff < den_ff, "division remainder not below divisor")
   `TFI_ASSERT_NOW(a_quo_bound, state_ff == S_FIN, quo_ff <= mag_ff, "quotient exceeds flux step magnitude")
   `TFI_ASSERT_NEXT(a_put_loads, (state_ff == S_PUT) && out_free, rsp_ch.valid, "result not presented after put")

endmodule

// ===== tb/table_time_flux_interpolator_unit_test.sv =====
// ----------------------------------------------------------------------------
// table_time_flux_interpolator_unit_test
// Self-checking bench for the time/flux table interpolator. A short table of
// directed items covers the empty table, first-entry hits, exact hits,
// unordered tables and queries past the end. Random table phases follow: each sets
// entry_count, loads ascending stamps (over 64 in use, unwritten entries only) and
// runs queries and stray loads. Each result is checked, most by an in-bench predictor.
// ----------------------------------------------------------------------------
module table_time_flux_interpolator_unit_test;
   import tfi_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 1130;
   localparam int DRAIN_CYCLES = 400;
   localparam int STALL_LIMIT  = 4000;
   localparam int HOLD_AFTER   = 150;
   localparam int HOLD_CYCLES  = 800;

   typedef enum logic [1:0] {ROW_LOAD, ROW_QUERY, ROW_COUNT} row_kind_type;

   typedef struct packed {
      logic                     req_type;
      logic [INDEX_W-1:0]       entry_index;
      logic [TIME_W-1:0]        stamp;
      logic signed [FLUX_W-1:0] vis;
      logic signed [FLUX_W-1:0] ir;
      logic [DAY_W-1:0]         day;
      logic [FRAC_W-1:0]        frac;
      logic                     flux_kind;
   } flux_req_type;

   typedef struct packed {
      logic signed [FLUX_W-1:0] flux;
      logic                     status;
   } flux_result_type;

   typedef struct packed {
      row_kind_type       kind;
      logic [INDEX_W-1:0] entry_index;
      logic [TIME_W-1:0]  stamp;
      logic [FLUX_W-1:0]  vis;
      logic [FLUX_W-1:0]  ir;
      logic [DAY_W-1:0]   day;
      logic [FRAC_W-1:0]  frac;
      logic               flux_kind;
      logic [COUNT_W-1:0] new_count;
      logic               typed;
      logic [FLUX_W-1:0]  exp_flux;
      logic               exp_status;
   } directed_row_type;

   localparam directed_row_type DIRECTED_ROWS [22] = '{
      '{ROW_QUERY, 8'd0, 38'h00_0000_0000, 32'h0000_0000, 32'h0000_0000,
        22'd0, 16'h0000, KIND_VIS, 9'd0, 1'b1, 32'h0000_0000, STAT_BEYOND},
      '{ROW_LOAD, 8'd0, 38'h00_0001_0000, 32'h7FFF_FFFF, 32'h8000_0000,
        22'd0, 16'h0000, KIND_VIS, 9'd0, 1'b0, 32'h0000_0000, STAT_OK},
      '{ROW_LOAD, 8'd1, 38'h00_0003_0000, 32'h8000_0000, 32'h7FFF_FFFF,
        22'd0, 16'h0000, KIND_VIS, 9'd0, 1'b0, 32'h0000_0000, STAT_OK},
      '{ROW_LOAD, 8'd2, 38'h3F_FFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
        22'd0, 16'h0000, KIND_VIS, 9'd0, 1'b0, 32'h0000_0000, STAT_OK},
      '{ROW_LOAD, 8'd255, 38'h3F_FFFF_FFFF, 32'h1234_5678, 32'h0000_0000,
        22'd0, 16'h0000, KIND_VIS, 9'd0, 1'b0, 32'h0000_0000, STAT_OK},
      '{ROW_COUNT, 8'd0, 38'h00_0000_0000, 32'h0000_0000, 32'h0000_0000,
        22'd0, 16'h0000, KIND_VIS, 9'd3, 1'b0, 32'h0000_0000, STAT_OK},
      '{ROW_QUERY, 8'd0, 38'h00_0000_0000, 32'h0000_0000, 32'h0000_0000,
        22'd0, 16'h0000, KIND_VIS, 9'd0, 1'b1, 32'h7FFF_FFFF, STAT_OK},
      '{ROW_QUERY, 8'd0, 38'h00_0000_0000, 32'h0000_0000, 32'h0000_0000,
        22'd1, 16'h0000, KIND_IR, 9'd0, 1'b1, 32'h8000_0000, STAT_OK},
      '{ROW_QUERY, 8'd0, 38'h00_0000_0000, 32'h0000_0000, 32'h0000_0000,
        22'd2, 16'h0000, KIND_VIS, 9'd0, 1'b0, 32'h0000_0000, STAT_OK},
      '{ROW_QUERY, 8'd0, 38'h00_0000_0000, 32'h0000_0000, 32'h0000_0000,
        22'd2, 16'h0001, KIND_IR, 9'd0, 1'b0, 32'h0000_0000, STAT_OK},
      '{ROW_QUERY, 8'd0, 38'h00_0000_0000, 32'h0000_0000, 32'h0000_0000,
        22'd3, 16'hFFFF, KIND_VIS, 9'd0, 1'b0, 32'h0000_0000, STAT_OK},
      '{ROW_QUERY, 8'd0, 38'h00_0000_0000, 32'h0000_0000, 32'h0000_0000,
        22'h3F_FFFF, 16'hFFFF, KIND_IR, 9'd0, 1'b1, 32'hFFFF_FFFF, STAT_OK},
      '{ROW_LOAD, 8'd1, 38'h00_0000_8000, 32'h0001_0000, 32'hFFFF_0000,
        22'd0, 16'h0000, KIND_VIS, 9'd0, 1'b0, 32'h0000_0000, STAT_OK},
      '{ROW_QUERY, 8'd0, 38'h00_0000_0000, 32'h0000_0000, 32'h0000_0000,
        22'd1, 16'h4000, KIND_VIS, 9'd0, 1'b0, 32'h0000_0000, STAT_OK},
      '{ROW_QUERY, 8'd0, 38'h00_0000_0000, 32'h0000_0000, 32'h0000_0000,
        22'd0, 16'hC000, KIND_IR, 9'd0, 1'b1, 32'h8000_0000, STAT_OK},
      '{ROW_COUNT, 8'd0, 38'h00_0000_0000, 32'h0000_0000, 32'h0000_0000,
        22'd0, 16'h0000, KIND_VIS, 9'd2, 1'b0, 32'h0000_0000, STAT_OK},
      '{ROW_QUERY, 8'd0, 38'h00_0000_0000, 32'h0000_0000, 32'h0000_0000,
        22'd5, 16'h0000, KIND_VIS, 9'd0, 1'b1, 32'h0000_0000, STAT_BEYOND},
      '{ROW_COUNT, 8'd0, 38'h00_0000_0000, 32'h0000_0000, 32'h0000_0000,
        22'd0, 16'h0000, KIND_VIS, 9'd0, 1'b0, 32'h0000_0000, STAT_OK},
      '{ROW_QUERY, 8'd0, 38'h00_0000_0000, 32'h0000_0000, 32'h0000_0000,
        22'h3F_FFFF, 16'hFFFF, KIND_IR, 9'd0, 1'b1, 32'h0000_0000, STAT_BEYOND},
      '{ROW_LOAD, 8'd3, 38'h00_0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
        22'd0, 16'h0000, KIND_VIS, 9'd0, 1'b0, 32'h0000_0000, STAT_OK},
      '{ROW_COUNT, 8'd0, 38'h00_0000_0000, 32'h0000_0000, 32'h0000_0000,
        22'd0, 16'h0000, KIND_VIS, 9'd4, 1'b0, 32'h0000_0000, STAT_OK},
      '{ROW_QUERY, 8'd0, 38'h00_0000_0000, 32'h0000_0000, 32'h0000_0000,
        22'd2, 16'h0000, KIND_VIS, 9'd0, 1'b0, 32'h0000_0000, STAT_OK}
   };

   logic clock;
   logic reset;

   tfi_req_if req_ch();
   tfi_rsp_if rsp_ch();
   tfi_csr_if csr_ch();

   table_time_flux_interpolator_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // predictor state
   logic [TIME_W-1:0]        time_tbl [TABLE_DEPTH];
   logic signed [FLUX_W-1:0] vis_tbl  [TABLE_DEPTH];
   logic signed [FLUX_W-1:0] ir_tbl   [TABLE_DEPTH];
   bit                       entry_written [TABLE_DEPTH];
   logic [COUNT_W-1:0]       table_count;

   flux_result_type flux_expected_q [$];

   int  errors;
   int  items_sent;
   int  loads_sent;
   int  queries_sent;
   int  random_items;
   int  results_checked;
   int  beyond_seen;
   int  count_writes;
   bit  steady_flow;

   always #5 clock = ~clock;

   function automatic int entries_in_use();
      return (table_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(table_count);
   endfunction

   function automatic flux_result_type interpolate_flux(input logic [TIME_W-1:0] t,
                                                        input logic kind);
      flux_result_type   r;
      int                used;
      int                i;
      int                hit;
      bit                found;
      logic signed [63:0] v1;
      logic signed [63:0] v2;
      logic signed [63:0] dv;
      logic signed [63:0] res;
      logic [127:0]      mag;
      logic [127:0]      span;
      logic [127:0]      quot;
      logic [TIME_W-1:0] t1;
      logic [TIME_W-1:0] t2;
      used  = entries_in_use();
      found = 1'b0;
      hit   = 0;
      for (i = 0; i < used; i++) begin
         if (!found && t <= time_tbl[i]) begin
            found = 1'b1;
            hit   = i;
         end
      end
      r.flux   = '0;
      r.status = STAT_BEYOND;
      if (found) begin
         v2 = (kind == KIND_IR) ? ir_tbl[hit] : vis_tbl[hit];
         if (hit == 0) begin
            res = v2;
         end else begin
            v1 = (kind == KIND_IR) ? ir_tbl[hit-1] : vis_tbl[hit-1];
            t1 = time_tbl[hit-1];
            t2 = time_tbl[hit];
            if (t1 >= t2) begin
               res = v1;
            end else begin
               dv   = v2 - v1;
               mag  = 128'((dv < 0) ? -dv : dv);
               span = 128'(t - t1);
               quot = (mag * span) / 128'(t2 - t1);
               res  = (dv < 0) ? v1 - $signed(quot[63:0]) : v1 + $signed(quot[63:0]);
            end
         end
         r.flux   = res[FLUX_W-1:0];
         r.status = STAT_OK;
      end
      return r;
   endfunction

   function automatic logic [TIME_W-1:0] rand_time();
      return {6'($urandom_range(0, 63)), 32'($urandom)};
   endfunction

   function automatic logic signed [FLUX_W-1:0] rand_flux();
      logic signed [FLUX_W-1:0] v;
      v = $urandom;
      if ($urandom_range(0, 3) == 0) begin
         v = $urandom_range(0, 4000);
         v = v - 2000;
      end
      return v;
   endfunction

   // query fields of a load are random noise
   function automatic flux_req_type make_load(input logic [INDEX_W-1:0] idx,
                                              input logic [TIME_W-1:0] stamp);
      flux_req_type it;
      it.req_type    = REQ_LOAD;
      it.entry_index = idx;
      it.stamp       = stamp;
      it.vis         = rand_flux();
      it.ir          = rand_flux();
      it.day         = DAY_W'($urandom);
      it.frac        = FRAC_W'($urandom);
      it.flux_kind   = 1'($urandom_range(0, 1));
      return it;
   endfunction

   task automatic maybe_pause();
      steady_flow = (random_items >= 300 && random_items < 460);
      if (!steady_flow && $urandom_range(0, 99) < 15) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic send_item(input flux_req_type it, input bit typed,
                            input flux_result_type typed_exp);
      req_ch.req_type    <= it.req_type;
      req_ch.entry_index <= it.entry_index;
      req_ch.entry_time  <= it.stamp;
      req_ch.entry_vis   <= it.vis;
      req_ch.entry_ir    <= it.ir;
      req_ch.query_day   <= it.day;
      req_ch.query_frac  <= it.frac;
      req_ch.flux_kind   <= it.flux_kind;
      req_ch.valid       <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
      if (it.req_type == REQ_LOAD) begin
         time_tbl[it.entry_index]      = it.stamp;
         vis_tbl[it.entry_index]       = it.vis;
         ir_tbl[it.entry_index]        = it.ir;
         entry_written[it.entry_index] = 1'b1;
         loads_sent++;
      end else begin
         queries_sent++;
         if (typed)
            flux_expected_q.push_back(typed_exp);
         else
            flux_expected_q.push_back(interpolate_flux({it.day, it.frac}, it.flux_kind));
      end
   endtask

   // only while idle: all results in, then room for a trailing load
   task automatic write_count(input logic [COUNT_W-1:0] value);
      req_ch.valid <= 1'b0;
      while (flux_expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_ch.entry_count <= value;
      csr_ch.valid       <= 1'b1;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      table_count = value;
      count_writes++;
   endtask

   // result checker and receiver
   initial begin
      flux_result_type exp_res;
      int              hold_left;
      bit              hold_done;
      hold_left    = 0;
      hold_done    = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (flux_expected_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, flux_value %h status %0d",
                        $time, rsp_ch.flux_value, rsp_ch.status);
            end else begin
               exp_res = flux_expected_q.pop_front();
               results_checked++;
               if (exp_res.status == STAT_BEYOND)
                  beyond_seen++;
               if (rsp_ch.flux_value !== exp_res.flux) begin
                  errors++;
                  $display("%0t: flux_value expected %h got %h",
                           $time, exp_res.flux, rsp_ch.flux_value);
               end
               if (rsp_ch.status !== exp_res.status) begin
                  errors++;
                  $display("%0t: status expected %0d got %0d",
                           $time, exp_res.status, rsp_ch.status);
               end
            end
         end
         if (!hold_done && results_checked >= HOLD_AFTER) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= steady_flow || ($urandom_range(0, 99) >= 15);
         end
      end
   end

   // watchdog
   initial begin
      int stall;
      stall = 0;
      while (stall < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
             (csr_ch.valid && csr_ch.ready))
            stall = 0;
         else
            stall++;
      end
      $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      int                 r;
      int                 i;
      int                 n;
      int                 k;
      int                 ops;
      int                 sel;
      int                 used;
      int                 phase;
      directed_row_type   row;
      flux_req_type       it;
      flux_result_type    typed_exp;
      logic [TIME_W-1:0]  stamp;
      logic [TIME_W-1:0]  lo;
      logic [COUNT_W-1:0] new_count;

      clock              = 1'b0;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.req_type    = REQ_LOAD;
      req_ch.entry_index = '0;
      req_ch.entry_time  = '0;
      req_ch.entry_vis   = '0;
      req_ch.entry_ir    = '0;
      req_ch.query_day   = '0;
      req_ch.query_frac  = '0;
      req_ch.flux_kind   = KIND_VIS;
      csr_ch.valid       = 1'b0;
      csr_ch.entry_count = '0;
      table_count        = '0;
      steady_flow        = 1'b0;
      for (i = 0; i < TABLE_DEPTH; i++) begin
         time_tbl[i]      = '0;
         vis_tbl[i]       = '0;
         ir_tbl[i]        = '0;
         entry_written[i] = 1'b0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < $size(DIRECTED_ROWS); r++) begin
         row = DIRECTED_ROWS[r];
         if (row.kind == ROW_COUNT) begin
            write_count(row.new_count);
         end else begin
            it.req_type    = (row.kind == ROW_LOAD) ? REQ_LOAD : REQ_QUERY;
            it.entry_index = row.entry_index;
            it.stamp       = row.stamp;
            it.vis         = row.vis;
            it.ir          = row.ir;
            it.day         = row.day;
            it.frac        = row.frac;
            it.flux_kind   = row.flux_kind;
            typed_exp.flux   = row.exp_flux;
            typed_exp.status = row.exp_status;
            maybe_pause();
            send_item(it, row.typed, typed_exp);
         end
      end

      // table phases: full table first, then saturated count, then mostly short tables
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 9);
         if (phase == 0)
            new_count = COUNT_W'(TABLE_DEPTH);
         else if (phase == 1)
            new_count = '1;
         else if (sel == 0)
            new_count = '0;
         else if (sel < 7)
            new_count = COUNT_W'($urandom_range(1, 12));
         else if (sel < 9)
            new_count = COUNT_W'($urandom_range(13, 64));
         else
            new_count = COUNT_W'($urandom_range(TABLE_DEPTH + 1, 511));
         write_count(new_count);
         used  = entries_in_use();
         stamp = {1'b0, 5'($urandom_range(0, 31)), 32'($urandom)};
         for (i = 0; i < used; i++) begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
               stamp = stamp;
            else if (sel < 7)
               stamp = stamp + $urandom_range(1, 4096);
            else
               stamp = stamp + $urandom_range(1, 1 << 24);
            if (used <= 64 || !entry_written[i]) begin
               it = make_load(INDEX_W'(i), stamp);
               maybe_pause();
               send_item(it, 1'b0, '0);
               random_items++;
            end
         end
         ops = (used <= 64) ? $urandom_range(25, 45) : 60;
         for (n = 0; n < ops && random_items < RANDOM_ITEMS; n++) begin
            it = make_load(INDEX_W'($urandom_range(0, TABLE_DEPTH - 1)), rand_time());
            if ($urandom_range(0, 3) != 0) begin
               sel = $urandom_range(0, 99);
               if (used == 0 || sel < 20) begin
                  stamp = rand_time();
               end else if (sel < 30) begin
                  stamp = ($urandom_range(0, 1) == 0) ? '1 :
                          time_tbl[used-1] + $urandom_range(1, 1000);
               end else begin
                  k  = $urandom_range(0, used - 1);
                  lo = (k > 0) ? time_tbl[k-1] : '0;
                  if (sel < 45 || time_tbl[k] <= lo)
                     stamp = time_tbl[k];
                  else
                     stamp = lo + 1 + rand_time() % (time_tbl[k] - lo);
               end
               it.req_type  = REQ_QUERY;
               it.day       = stamp[TIME_W-1:FRAC_W];
               it.frac      = stamp[FRAC_W-1:0];
               it.flux_kind = 1'($urandom_range(0, 1));
            end
            maybe_pause();
            send_item(it, 1'b0, '0);
            random_items++;
         end
         phase++;
      end

      req_ch.valid <= 1'b0;
      while (flux_expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items: %0d table loads, %0d queries over %0d entry_count settings",
               items_sent, loads_sent, queries_sent, count_writes);
      $display("Checked %0d results, %0d of them past the table end",
               results_checked, beyond_seen);
      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== table_time_flux_interpolator_unit.f =====
+incdir+rtl/core
rtl/core/tfi_pkg.sv
rtl/core/tfi_channels.sv
rtl/core/tfi_addsub.sv
rtl/core/table_time_flux_interpolator_unit.sv
tb/table_time_flux_interpolator_unit_test.sv
